### rtl/core/vdi_pkg.sv
package vdi_pkg;

  // Table geometry
  localparam int unsigned MaxUnique = 64;
  localparam int unsigned SlotW     = $clog2(MaxUnique);
  localparam int unsigned CountW    = $clog2(MaxUnique + 1);

  // Field widths
  localparam int unsigned CoordW    = 32;
  localparam int unsigned BaseW     = 24;
  localparam int unsigned IdxW      = 25;
  localparam int unsigned InDataW   = 3 * CoordW;
  localparam int unsigned OutDataW  = ((IdxW + 7) / 8) * 8;

  // One vertex as stored in a table entry
  typedef struct packed {
    logic [CoordW-1:0] z;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] x;
  } vdi_vtx_t;

  // Search token handed from cell to cell
  typedef struct packed {
    logic             valid;
    logic             hit;
    logic [SlotW-1:0] slot;
    vdi_vtx_t         vtx;
  } vdi_token_t;

endpackage

### rtl/core/vdi_cell.sv
module vdi_cell
  import vdi_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [SlotW-1:0]  slot_id_i,
  input  logic [CountW-1:0] count_i,
  input  vdi_token_t        tok_i,
  output vdi_token_t        tok_o
);

  vdi_vtx_t   entry_q;
  vdi_token_t tok_d, tok_q;
  logic       live;
  logic       match;
  logic       fill;

  // Compare against the held entry when it lies below the fill level
  assign live  = tok_i.valid && !tok_i.hit;
  assign match = live && (CountW'(slot_id_i) < count_i) && (entry_q == tok_i.vtx);
  assign fill  = live && (CountW'(slot_id_i) == count_i);

  always_comb begin
    tok_d = tok_i;
    if (match) begin
      tok_d.hit  = 1'b1;
      tok_d.slot = slot_id_i;
    end
  end

  // Store a new vertex in the first free entry as the token passes
  always_ff @(posedge clk_i) begin
    if (fill) begin
      entry_q <= tok_i.vtx;
    end
  end

  // Hand the token on to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

### rtl/core/vdi_chain.sv
module vdi_chain
  import vdi_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CountW-1:0] count_i,
  input  vdi_token_t        tok_i,
  output vdi_token_t        tok_o
);

  vdi_token_t link [MaxUnique+1];

  assign link[0] = tok_i;

  // One cell per table slot, token flows from slot 0 upwards
  for (genvar g = 0; g < MaxUnique; g++) begin : g_cell
    vdi_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .slot_id_i (SlotW'(g)),
      .count_i   (count_i),
      .tok_i     (link[g]),
      .tok_o     (link[g+1])
    );
  end

  assign tok_o = link[MaxUnique];

endmodule

### rtl/core/vertex_dedup_indexer_core.sv
// Vertex deduplication indexer.
// Slave stream: one vertex per transaction, tdata holds x, y, z bit patterns,
// tuser holds the first-of-mesh flag, which empties the unique table first.
// Master stream: one result per vertex, tdata holds the vertex index (base
// plus slot), tuser holds is_new and overflow.
// Configuration channel: cfg_data_i sets the index base; always ready, write
// it only while no vertex is in flight.
// Each vertex enters a launch register, then walks a row of MaxUnique compare
// cells, one cell per cycle; each cell holds one table entry. From the last
// cell the result is registered in the output register or the hold register.
// One vertex is in flight at a time, so when the receiver keeps up the row
// length sets the rate.
// A result that finds the output register occupied waits in a hold register;
// a new vertex may be accepted while a result waits to be taken, but s_axis
// ready stays low until its predecessor's result has reached the output.
// Reset empties the table (fill count to zero), clears the index base and
// drops any transaction in flight; table contents are left as they are.
module vertex_dedup_indexer_core
  import vdi_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Slave stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // x_bits, y_bits, z_bits
  input  logic                s_axis_tuser,   // first_of_mesh
  // Master stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // vertex_index, zero padding
  output logic [1:0]          m_axis_tuser,   // is_new, overflow
  // Configuration
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [BaseW-1:0]    cfg_data_i
);

  typedef struct packed {
    logic [IdxW-1:0] index;
    logic            is_new;
    logic            overflow;
  } vdi_result_t;

  logic [BaseW-1:0]  base_q;
  logic [CountW-1:0] count_d, count_q;
  logic              busy_q;
  logic              accept;
  vdi_token_t        launch_d, launch_q;
  vdi_token_t        exit_tok;
  vdi_result_t       res;
  vdi_result_t       out_q, hold_q;
  logic              out_valid_q, hold_valid_q;
  logic              out_free;
  logic              table_full;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !busy_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign table_full    = (count_q == CountW'(MaxUnique));

  // Hold the index base
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (cfg_valid_i) begin
      base_q <= cfg_data_i;
    end
  end

  // Build the search token for an accepted vertex
  always_comb begin
    launch_d.valid = accept;
    launch_d.hit   = 1'b0;
    launch_d.slot  = '0;
    launch_d.vtx.x = s_axis_tdata[CoordW-1:0];
    launch_d.vtx.y = s_axis_tdata[2*CoordW-1:CoordW];
    launch_d.vtx.z = s_axis_tdata[3*CoordW-1:2*CoordW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      launch_q <= '0;
    end else begin
      launch_q <= launch_d;
    end
  end

  vdi_chain u_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .count_i (count_q),
    .tok_i   (launch_q),
    .tok_o   (exit_tok)
  );

  // Form the result of the token leaving the row
  always_comb begin
    res = '0;
    if (exit_tok.hit) begin
      res.index = IdxW'(base_q) + IdxW'(exit_tok.slot);
    end else if (!table_full) begin
      res.index  = IdxW'(base_q) + IdxW'(count_q);
      res.is_new = 1'b1;
    end else begin
      res.overflow = 1'b1;
    end
  end

  // Empty the table on first-of-mesh, advance the fill level on insertion
  always_comb begin
    count_d = count_q;
    if (accept && s_axis_tuser) begin
      count_d = '0;
    end else if (exit_tok.valid && !exit_tok.hit && !table_full) begin
      count_d = count_q + CountW'(1);
    end
  end

  // Fill level, output register, hold register and busy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      busy_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      hold_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        busy_q <= 1'b1;
      end
      if (exit_tok.valid) begin
        if (out_free) begin
          out_valid_q <= 1'b1;
          busy_q      <= 1'b0;
        end else begin
          hold_valid_q <= 1'b1;
        end
      end else if (hold_valid_q && out_free) begin
        out_valid_q  <= 1'b1;
        hold_valid_q <= 1'b0;
        busy_q       <= 1'b0;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exit_tok.valid) begin
      if (out_free) begin
        out_q <= res;
      end else begin
        hold_q <= res;
      end
    end else if (hold_valid_q && out_free) begin
      out_q <= hold_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW-IdxW){1'b0}}, out_q.index};
  assign m_axis_tuser  = {out_q.overflow, out_q.is_new};

endmodule

### rtl/core/vdi_checker.sv
module vdi_checker
  import vdi_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic [1:0]          m_axis_tuser
);

  // A vertex is never both inserted and overflowed
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("is_new and overflow both set");

  // Overflow reports a zero index
  a_overflow_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata == '0))
    else $error("overflow with nonzero index");

  // Only one vertex in flight: ready drops after each transaction
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second vertex accepted while one is in flight");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind vertex_dedup_indexer_core vdi_checker u_vdi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

### sim/vertex_dedup_indexer_core_tb.sv
module vertex_dedup_indexer_core_tb import vdi_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam realtime HalfPeriod    = 6ns;
  localparam int      ResetCycles   = 12;
  localparam int      DrainCycles   = MaxUnique + 8;
  localparam int      TimeoutCycles = 2_000_000;
  localparam int      TargetItems   = 800;

  // Coordinate patterns of interest
  localparam logic [CoordW-1:0] PosZero = 32'h0000_0000;
  localparam logic [CoordW-1:0] NegZero = 32'h8000_0000;
  localparam logic [CoordW-1:0] QNaN    = 32'h7FC0_0000;
  localparam logic [CoordW-1:0] PosInf  = 32'h7F80_0000;
  localparam logic [CoordW-1:0] OneF    = 32'h3F80_0000;
  localparam logic [CoordW-1:0] AllOnes = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [IdxW-1:0] index;
    logic            is_new;
    logic            overflow;
  } vdi_result_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;   // x_bits, y_bits, z_bits
  logic                s_axis_tuser  = 1'b0; // first_of_mesh
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;         // vertex_index, zero padding
  logic [1:0]          m_axis_tuser;         // is_new, overflow
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [BaseW-1:0]    cfg_data_i    = '0;

  // Shadow of the block's state
  vdi_vtx_t         uniq_tbl [MaxUnique];
  int unsigned      uniq_cnt = 0;
  logic [BaseW-1:0] idx_base = '0;

  vdi_result_t vertex_results [$];
  int          mismatches  = 0;
  int          items_sent  = 0;
  int          cycle_count = 0;
  int          rdy_hold    = 0;
  bit          idling      = 1'b1;

  vertex_dedup_indexer_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #HalfPeriod clk_i = ~clk_i;

  // Look up a vertex in the unique table, append it when it is new
  function automatic vdi_result_t index_vertex(input logic first, input vdi_vtx_t v);
    vdi_result_t r;
    int          hit_slot;
    hit_slot = -1;
    r = '0;
    if (first) uniq_cnt = 0;
    for (int s = 0; s < uniq_cnt; s++) begin
      if (hit_slot < 0 && uniq_tbl[s] == v) hit_slot = s;
    end
    if (hit_slot >= 0) begin
      r.index = IdxW'(idx_base) + IdxW'(hit_slot);
    end else if (uniq_cnt < MaxUnique) begin
      uniq_tbl[uniq_cnt] = v;
      r.index  = IdxW'(idx_base) + IdxW'(uniq_cnt);
      r.is_new = 1'b1;
      uniq_cnt++;
    end else begin
      r.overflow = 1'b1;
    end
    return r;
  endfunction

  // No gap while idling is off; else mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (!idling) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  function automatic vdi_vtx_t vtx(input logic [CoordW-1:0] x, y, z);
    vdi_vtx_t v;
    v.x = x;
    v.y = y;
    v.z = z;
    return v;
  endfunction

  function automatic logic [CoordW-1:0] rand_coord();
    case ($urandom_range(0, 11))
      0:       return PosZero;
      1:       return NegZero;
      2:       return QNaN;
      3:       return PosInf;
      4:       return OneF;
      5:       return AllOnes;
      default: return $urandom;
    endcase
  endfunction

  function automatic vdi_vtx_t rand_vertex();
    return vtx(rand_coord(), rand_coord(), rand_coord());
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Offer one vertex, predict its result on acceptance, then idle a while if pick_gap asks for a gap
  task automatic send_vertex(input logic first, input vdi_vtx_t v);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= v;
    s_axis_tuser  <= first;
    do @(posedge clk_i); while (!s_axis_tready);
    vertex_results = {vertex_results, index_vertex(first, v)};
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Hold the sender until every pending result is back, then let the row settle
  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    while (vertex_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_index_base(input logic [BaseW-1:0] value);
    wait_results_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    idx_base = value;
  endtask

  // Signed zeros, NaN patterns, extreme coordinates, mesh marks and the top index base
  task automatic test_directed();
    idling = 1'b1;
    send_vertex(1'b0, vtx(PosZero, PosZero, PosZero));
    send_vertex(1'b0, vtx(PosZero, PosZero, PosZero));
    send_vertex(1'b0, vtx(AllOnes, AllOnes, AllOnes));
    send_vertex(1'b0, vtx(NegZero, PosZero, PosZero));
    send_vertex(1'b0, vtx(PosZero, NegZero, PosZero));
    send_vertex(1'b0, vtx(PosZero, PosZero, NegZero));
    send_vertex(1'b0, vtx(QNaN, OneF, PosInf));
    send_vertex(1'b0, vtx(QNaN, OneF, PosInf));
    send_vertex(1'b0, vtx(NegZero, PosZero, PosZero));
    send_vertex(1'b1, vtx(AllOnes, AllOnes, AllOnes));
    send_vertex(1'b0, vtx(PosZero, PosZero, PosZero));
    send_vertex(1'b0, vtx(AllOnes, AllOnes, AllOnes));
    send_vertex(1'b1, vtx(PosZero, PosZero, PosZero));
    send_vertex(1'b1, vtx(PosZero, PosZero, PosZero));
    write_index_base(24'hFF_FFFF);
    send_vertex(1'b1, vtx(OneF, QNaN, NegZero));
    send_vertex(1'b0, vtx(OneF, QNaN, PosZero));
    send_vertex(1'b0, vtx(OneF, QNaN, NegZero));
    send_vertex(1'b0, vtx(OneF, QNaN, PosZero));
  endtask

  // Fill the table, then check that new vertices overflow and stored ones still hit
  task automatic test_table_full();
    vdi_vtx_t fill [$];
    vdi_vtx_t v;
    write_index_base(24'hFF_FFFF);
    idling = 1'b0;
    for (int s = 0; s < MaxUnique; s++) begin
      v = rand_vertex();
      v.y = 32'hA500_0000 ^ 32'(s);
      fill = {fill, v};
      send_vertex(s == 0, v);
      if (s == MaxUnique / 2) idling = 1'b1;
    end
    for (int i = 0; i < 12; i++) begin
      if (i % 3 == 0) v = fill[$urandom_range(0, MaxUnique - 1)];
      else v = rand_vertex();
      send_vertex(1'b0, v);
    end
    send_vertex(1'b0, v);
    send_vertex(1'b0, fill[MaxUnique - 1]);
    send_vertex(1'b0, fill[0]);
    send_vertex(1'b1, v);
    send_vertex(1'b0, fill[0]);
  endtask

  // Meshes with repeated, near-miss and fresh vertices; stray marks as noise; index base rewritten now and then
  task automatic test_random_meshes(input int target);
    vdi_vtx_t                seen [$];
    vdi_vtx_t                v;
    logic [InDataW-1:0]      flip;
    int                      mesh_len;
    int                      r;
    int                      phase;
    logic                    first;
    phase = 0;
    write_index_base(24'd1);
    while (items_sent < target) begin
      idling = ($urandom_range(0, 3) != 0);
      mesh_len = ($urandom_range(0, 9) == 0) ? $urandom_range(70, 110)
                                             : $urandom_range(1, 40);
      for (int i = 0; i < mesh_len; i++) begin
        r = $urandom_range(0, 99);
        if (seen.size() != 0 && r < 55) begin
          v = seen[$urandom_range(0, seen.size() - 1)];
        end else if (seen.size() != 0 && r < 70) begin
          flip = '0;
          flip[$urandom_range(0, InDataW - 1)] = 1'b1;
          v = seen[$urandom_range(0, seen.size() - 1)];
          v = v ^ flip;
        end else begin
          v = rand_vertex();
        end
        first = (i == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 49) == 0);
        if (first) seen.delete();
        seen = {seen, v};
        send_vertex(first, v);
      end
      phase++;
      if (phase % 6 == 0) begin
        case ($urandom_range(0, 3))
          0:       write_index_base('0);
          1:       write_index_base(24'hFF_FFFF);
          default: write_index_base(BaseW'($urandom));
        endcase
      end else if (phase == 9) begin
        wait_results_drained();
      end
    end
  endtask

  // Receiver: random stalls, no new ones while idling is off
  always @(posedge clk_i) begin : drive_ready
    int stall;
    if (rdy_hold > 0) begin
      rdy_hold <= rdy_hold - 1;
    end else begin
      stall = pick_gap();
      if (stall == 0) begin
        m_axis_tready <= 1'b1;
        rdy_hold      <= $urandom_range(0, 5);
      end else begin
        m_axis_tready <= 1'b0;
        rdy_hold      <= stall - 1;
      end
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin : check_results
    vdi_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (vertex_results.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata, 0);
      end else begin
        want = vertex_results.pop_front();
        if (m_axis_tdata[IdxW-1:0] !== want.index)
          report_mismatch("vertex_index", m_axis_tdata[IdxW-1:0], want.index);
        if (m_axis_tuser[0] !== want.is_new)
          report_mismatch("is_new", m_axis_tuser[0], want.is_new);
        if (m_axis_tuser[1] !== want.overflow)
          report_mismatch("overflow", m_axis_tuser[1], want.overflow);
      end
    end
  end

  // Abort a run that hangs
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= TimeoutCycles) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_table_full();
    test_random_meshes(TargetItems);
    wait_results_drained();
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

### filelist.f
rtl/core/vdi_pkg.sv
rtl/core/vdi_cell.sv
rtl/core/vdi_chain.sv
rtl/core/vertex_dedup_indexer_core.sv
rtl/core/vdi_checker.sv
sim/vertex_dedup_indexer_core_tb.sv
